>>> sv/binary_min_heap_queue_core_assert.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_assert.svh
// Assertion macros for the min-heap queue core; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
// lbl: label, clk: clock, rstn: active-low reset, prop: property expression
`define BMHQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("bmhq: assertion failed");
// cond must never hold at a clock edge
`define BMHQ_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("bmhq: forbidden condition seen");
`else
`define BMHQ_ASSERT(lbl, clk, rstn, prop)
`define BMHQ_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, codes and the result record of the min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int HEAP_DEPTH_DEF = 16;
	localparam int KEY_W          = 32;
	localparam int CNT_OUT_W      = 5;
	localparam int STAT_W         = 2;

	// command codes (carried in tuser)
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [KEY_W-1:0] min_key;
		logic                    is_empty;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic [STAT_W-1:0]       status;
	} res_t;

endpackage

>>> sv/bmhq_store.sv
// ----------------------------------------------------------------------------
// bmhq_store
// Heap key storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmhq_store
	import bmhq_pkg::*;
#(
	parameter int  HEAP_DEPTH = HEAP_DEPTH_DEF,
	localparam int AW         = $clog2(HEAP_DEPTH)
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [KEY_W-1:0] rd_data,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic signed [KEY_W-1:0] wr_data
);

	logic signed [KEY_W-1:0] mem [HEAP_DEPTH];
	logic signed [KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bmhq_seq.sv
// ----------------------------------------------------------------------------
// bmhq_seq
// Sequencer: insert with sift-up, remove-min with sift-down, one memory
// access pair per cycle; the moving key stays in a register (hole method).
// ----------------------------------------------------------------------------
module bmhq_seq
	import bmhq_pkg::*;
#(
	parameter int  HEAP_DEPTH = HEAP_DEPTH_DEF,
	localparam int AW         = $clog2(HEAP_DEPTH),
	localparam int CW         = $clog2(HEAP_DEPTH + 1),
	localparam int XW         = CW + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    cmd,
	input  logic signed [KEY_W-1:0] key_in,
	output logic                    idle,
	output logic                    res_valid,
	input  logic                    res_ready,
	output res_t                    res,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  logic signed [KEY_W-1:0] rd_data,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output logic signed [KEY_W-1:0] wr_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_DN_L = 3'd3;
	localparam logic [2:0] S_DN_R = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]              state_q, state_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic [AW-1:0]           pos_q, pos_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic signed [KEY_W-1:0] lval_q, lval_d;
	logic signed [KEY_W-1:0] root_q, root_d;
	logic [STAT_W-1:0]       stat_q, stat_d;

	logic [AW-1:0]           par_idx;
	logic [XW-1:0]           l_idx, r_idx, nl_idx;
	logic signed [KEY_W-1:0] lval_src, lbest;
	logic                    left_lt, right_lt, pick_r, pick_l;
	logic [AW-1:0]           mv_idx;
	logic signed [KEY_W-1:0] mv_val;

	// sift-down child selection; strict compares keep equal keys in place
	assign par_idx  = AW'((pos_q - 1'b1) >> 1);
	assign l_idx    = XW'({pos_q, 1'b1});
	assign r_idx    = l_idx + 1'b1;
	assign lval_src = (state_q == S_DN_L) ? rd_data : lval_q;
	assign left_lt  = lval_src < key_q;
	assign lbest    = left_lt ? lval_q : key_q;
	assign right_lt = rd_data < lbest;
	assign pick_r   = (state_q == S_DN_R) && right_lt;
	assign pick_l   = !pick_r && left_lt;
	assign mv_idx   = pick_r ? AW'(r_idx) : AW'(l_idx);
	assign mv_val   = pick_r ? rd_data : lval_src;
	assign nl_idx   = XW'({mv_idx, 1'b1});

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		key_d   = key_q;
		lval_d  = lval_q;
		stat_d  = stat_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = key_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					stat_d = ST_OK;
					if (cmd == CMD_INSERT) begin
						if (cnt_q == CW'(HEAP_DEPTH)) begin
							stat_d  = ST_FULL;
							state_d = S_OUT;
						end else begin
							key_d = key_in;
							cnt_d = cnt_q + 1'b1;
							pos_d = AW'(cnt_q);
							if (cnt_q == '0) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = key_in;
								state_d = S_OUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'((cnt_q - 1'b1) >> 1);
								state_d = S_UP;
							end
						end
					end else begin
						if (cnt_q == '0) begin
							stat_d  = ST_EMPTY;
							state_d = S_OUT;
						end else begin
							cnt_d = cnt_q - 1'b1;
							if (cnt_q == CW'(1)) begin
								state_d = S_OUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(cnt_q - 1'b1);
								state_d = S_LAST;
							end
						end
					end
				end
			end
			S_UP: begin
				if (rd_data > key_q) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
					pos_d   = par_idx;
					if (par_idx == '0) begin
						state_d = S_WR;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'((par_idx - 1'b1) >> 1);
					end
				end else begin
					wr_en   = 1'b1;
					state_d = S_OUT;
				end
			end
			S_LAST: begin
				key_d = rd_data;
				pos_d = '0;
				if (cnt_q > CW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = AW'(1);
					state_d = S_DN_L;
				end else begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = rd_data;
					state_d = S_OUT;
				end
			end
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L) begin
					lval_d = rd_data;
				end
				if (state_q == S_DN_L && r_idx < XW'(cnt_q)) begin
					rd_en   = 1'b1;
					rd_addr = AW'(r_idx);
					state_d = S_DN_R;
				end else if (pick_r || pick_l) begin
					wr_en   = 1'b1;
					wr_data = mv_val;
					pos_d   = mv_idx;
					if (nl_idx < XW'(cnt_q)) begin
						rd_en   = 1'b1;
						rd_addr = AW'(nl_idx);
						state_d = S_DN_L;
					end else begin
						state_d = S_WR;
					end
				end else begin
					wr_en   = 1'b1;
					state_d = S_OUT;
				end
			end
			S_WR: begin
				wr_en   = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// shadow of entry zero, so the minimum needs no extra read
	assign root_d = (wr_en && wr_addr == '0) ? wr_data : root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		key_q  <= key_d;
		lval_q <= lval_d;
		root_q <= root_d;
		stat_q <= stat_d;
	end

	assign idle            = state_q == S_IDLE;
	assign res_valid       = state_q == S_OUT;
	assign res.min_key     = (cnt_q == '0) ? '0 : root_q;
	assign res.is_empty    = cnt_q == '0;
	assign res.entry_count = CNT_OUT_W'(cnt_q);
	assign res.status      = stat_q;

endmodule

>>> sv/binary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Insert sifts the new key up L levels (at most log2(HEAP_DEPTH)); remove-min
//   moves the last key to the root and sifts it down L levels; a refused item,
//   an empty-heap insert or removing the only key goes straight to the result.
// Each item runs to completion: the next item is taken only once its
//   predecessor's result has passed to the output register.
// Rate is set by the key memory's single read port: sift-up takes one read per
//   level, sift-down two reads (left, right child) per level.
// Reset clears the count and control; stored keys need no clearing.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_core_assert.svh"

module binary_min_heap_queue_core
	import bmhq_pkg::*;
#(
	parameter int  HEAP_DEPTH = HEAP_DEPTH_DEF,
	localparam int AW         = $clog2(HEAP_DEPTH),
	localparam int OUT_W      = KEY_W + 1 + CNT_OUT_W + STAT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [KEY_W-1:0] s_axis_tdata,   // [31:0] key_in
	input  logic             s_axis_tuser,   // [0] cmd: 0 insert, 1 remove-min
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // [31:0] min_key, [32] is_empty,
	                                         // [37:33] entry_count, [39:38] status
);

	logic                    in_fire;
	logic                    seq_idle;
	logic                    res_valid, res_ready, res_fire;
	res_t                    res;
	logic                    rd_en, wr_en;
	logic [AW-1:0]           rd_addr, wr_addr;
	logic signed [KEY_W-1:0] rd_data, wr_data;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	// take a new item whenever the sequencer is idle, even with a result
	// still parked in the output register
	assign s_axis_tready = seq_idle;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// sequencer: count, hole position, moving key and root shadow
	bmhq_seq #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.cmd      (s_axis_tuser),
		.key_in   ($signed(s_axis_tdata)),
		.idle     (seq_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// heap key memory; sift reads and writes never hit the same entry
	// in one cycle, so no forwarding is needed
	bmhq_store #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_store (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// output register: hand over a result when the slot is free or draining
	assign res_ready = !out_valid_q || m_axis_tready;
	assign res_fire  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// pack fields lowest first: min_key, is_empty, entry_count, status
	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_data_q <= {res.status, res.entry_count, res.is_empty, res.min_key};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a result is only handed over while the sequencer is busy, never with a new item
	`BMHQ_NEVER(a_no_accept_with_result, clk, arst_n, in_fire && res_fire)
	// a refused insert reports a full heap
	`BMHQ_ASSERT(a_full_count, clk, arst_n, res_fire && res.status == ST_FULL |-> res.entry_count == CNT_OUT_W'(HEAP_DEPTH) && !res.is_empty)
	// a refused remove reports an empty heap with a zero minimum
	`BMHQ_ASSERT(a_empty_flag, clk, arst_n, res_fire && res.status == ST_EMPTY |-> res.is_empty && res.min_key == '0)

endmodule

>>> bench/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Watches both stream channels of the min-heap queue core, keeps its own heap
// to predict one result per accepted item, and compares every result.
// ----------------------------------------------------------------------------
module bmhq_checker
	import bmhq_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
	localparam int OUT_W     = KEY_W + 1 + CNT_OUT_W + STAT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [KEY_W-1:0] s_axis_tdata,
	input  logic             s_axis_tuser,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int unsigned      fail_count,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
	int unsigned             heap_fill;
	res_t                    queued_results [$];

	// Apply one insert or remove-min to the shadow heap; return the result.
	function automatic res_t apply_heap_op(input logic op, input logic signed [KEY_W-1:0] key);
		int unsigned             pos;
		int unsigned             parent;
		int unsigned             child;
		int unsigned             best;
		logic                    settled;
		logic signed [KEY_W-1:0] tmp;
		res_t                    r;
		r.status = ST_OK;
		if (op == CMD_INSERT) begin
			if (heap_fill >= HEAP_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				heap_keys[heap_fill] = key;
				pos = heap_fill;
				heap_fill++;
				settled = 1'b0;
				// move up only while the parent is strictly larger
				while (pos > 0 && !settled) begin
					parent = (pos - 1) / 2;
					if (heap_keys[parent] <= heap_keys[pos]) begin
						settled = 1'b1;
					end else begin
						tmp               = heap_keys[parent];
						heap_keys[parent] = heap_keys[pos];
						heap_keys[pos]    = tmp;
						pos               = parent;
					end
				end
			end
		end else if (heap_fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			heap_fill--;
			heap_keys[0] = heap_keys[heap_fill];
			pos = 0;
			settled = 1'b0;
			while (!settled) begin
				best  = pos;
				child = 2 * pos + 1;
				if (child < heap_fill && heap_keys[child] < heap_keys[best])
					best = child;
				if (child + 1 < heap_fill && heap_keys[child + 1] < heap_keys[best])
					best = child + 1;
				if (best == pos) begin
					settled = 1'b1;
				end else begin
					tmp             = heap_keys[pos];
					heap_keys[pos]  = heap_keys[best];
					heap_keys[best] = tmp;
					pos             = best;
				end
			end
		end
		r.min_key     = (heap_fill > 0) ? heap_keys[0] : '0;
		r.is_empty    = (heap_fill == 0);
		r.entry_count = CNT_OUT_W'(heap_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		res_t got;
		if (!arst_n) begin
			heap_fill = 0;
			queued_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				queued_results.push_back(apply_heap_op(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.min_key     = m_axis_tdata[KEY_W-1:0];
				got.is_empty    = m_axis_tdata[KEY_W];
				got.entry_count = m_axis_tdata[KEY_W+1 +: CNT_OUT_W];
				got.status      = m_axis_tdata[KEY_W+1+CNT_OUT_W +: STAT_W];
				if (queued_results.size() == 0) begin
					$display("%0t: result with no item pending: expected none, got tdata %h",
						$time, m_axis_tdata);
					fail_count++;
				end else begin
					want = queued_results.pop_front();
					if (got.min_key !== want.min_key) begin
						$display("%0t: min_key expected %0d, got %0d",
							$time, want.min_key, got.min_key);
						fail_count++;
					end
					if (got.is_empty !== want.is_empty) begin
						$display("%0t: is_empty expected %b, got %b",
							$time, want.is_empty, got.is_empty);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d, got %0d",
							$time, want.entry_count, got.entry_count);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, got.status);
						fail_count++;
					end
				end
			end
			pending = queued_results.size();
		end
	end

endmodule

>>> bench/tb_binary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue_core
// Drives insert and remove-min items into the min-heap queue core with random
// gaps and back-pressure; a checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_core
	import bmhq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = HEAP_DEPTH_DEF;
	localparam int OUT_W        = KEY_W + 1 + CNT_OUT_W + STAT_W;
	localparam int TOTAL_ITEMS  = 1150;
	localparam int CALM_ITEMS   = 100;   // final stretch without any idling
	localparam int HOLD_AT      = 300;   // item index where the receiver holds off
	localparam int PAUSE_AT     = 600;   // item index where the sender drains
	localparam int LONG_HOLD    = 300;   // cycles of the long receiver hold-off
	localparam int DRAIN_CYCLES = 20;    // comfortably above the worst-case latency

	// Extremes, sign patterns and repeated keys for the directed fill.
	localparam logic [KEY_W-1:0] DIRECTED_KEYS [16] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFF9,
		32'hFFFF_FFF9, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0064,
		32'hFFFF_FF9C, 32'h0000_0003, 32'h0000_0003, 32'h7FFF_FFFF
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [KEY_W-1:0] s_axis_tdata = '0;   // [31:0] key_in
	logic             s_axis_tuser = 1'b0; // [0] cmd
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // [31:0] min_key, [32] is_empty,
	                                       // [37:33] entry_count, [39:38] status
	int unsigned      fail_count;
	int unsigned      pending;

	// calm and hold_req are shared between the sender and receiver processes.
	logic             calm = 1'b0;        // set for the final stretch: no idling
	logic             hold_req = 1'b0;    // ask the receiver for one long hold-off
	logic             tx_idle_on = 1'b1;  // sender gaps enabled in this segment

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	binary_min_heap_queue_core #(
		.HEAP_DEPTH(DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	bmhq_checker #(
		.HEAP_DEPTH(DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Offer one item and hold it until the core takes it. Ready is looked at
	// on the falling edge, where it is settled, so the following rising edge
	// is the accepting one. Optionally drop valid for a random gap afterwards.
	task automatic offer_item(input logic op, input logic [KEY_W-1:0] key);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= key;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		if (tx_idle_on && !calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Receiver: random ready runs and stall bursts, one long hold-off when
	// asked, and steady ready once the run has gone calm.
	initial begin : receiver
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// hold off long enough that the core fills up and stalls its input
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned      sent;
		int unsigned      ins_pct;
		logic             op;
		logic [KEY_W-1:0] key;

		// hold reset, then release it on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove from an empty heap, fill to the brim with extremes
		// and repeated keys, try one insert too many, then pop a few.
		offer_item(CMD_REMOVE, $urandom);
		for (int i = 0; i < DEPTH; i++)
			offer_item(CMD_INSERT, DIRECTED_KEYS[i % 16]);
		offer_item(CMD_INSERT, 32'h1234_5678);
		for (int i = 0; i < 6; i++)
			offer_item(CMD_REMOVE, $urandom);
		sent = DEPTH + 8;

		// Random: segments with their own insert bias, so the count swings
		// between empty and full, and their own sender idling setting.
		ins_pct = 50;
		while (sent < TOTAL_ITEMS) begin
			if (sent % 40 == 0) begin
				ins_pct    = $urandom_range(10, 90);
				tx_idle_on = ($urandom_range(0, 9) < 7);
			end
			if (sent >= TOTAL_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (sent == HOLD_AT)
				hold_req = 1'b1;
			if (sent == PAUSE_AT) begin
				// drain: stop offering until every result is back
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
			case ($urandom_range(0, 7))
				0, 1:    key = 32'($urandom_range(0, 6)) - 32'd3;   // near zero, many repeats
				2:       key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: key = $urandom;
			endcase
			offer_item(op, key);
			sent++;
		end

		// finish: let every result arrive, then give the core a few spare cycles
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
